// ===== design/tlvd_pkg.sv =====
// tlvd_pkg: shared types and constants for the TLV stream deframer.
// Used by the parser front end, the result queue, the output stage and the top level.
`default_nettype none
package tlvd_pkg;

  // Header layout: id bytes, then length bytes, both big-endian
  localparam logic [2:0] ID_BYTES  = 3'd2;
  localparam logic [2:0] LEN_BYTES = 3'd2;
  localparam logic [2:0] HDR_TOTAL = ID_BYTES + LEN_BYTES;

  // Reset value of the maximum body length register
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // Result queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_BODY     = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_TOO_LONG = 2'd2;
  localparam status_t ST_LINK     = 2'd3;

  // One classified result
  typedef struct packed {
    logic [15:0] msg_id;
    logic [7:0]  body_byte;
    logic        last;
    status_t     status;
  } res_t;

endpackage
`default_nettype wire

// ===== design/tlvd_front.sv =====
// tlvd_front: header parser and byte classifier of the TLV deframer.
// Depends on tlvd_pkg; pushes at most one result per accepted byte into the queue.
`default_nettype none
module tlvd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          link_error,
  input  wire logic [15:0]   max_body_len,
  output tlvd_pkg::res_t     push_data,
  output logic               push
);
  import tlvd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_CLOSED
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;

  // Classify the accepted byte and advance the parse state
  always_comb begin
    logic [15:0] id_base;
    logic [15:0] len_base;
    logic [2:0]  hc_inc;
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    push      = 1'b0;
    push_data = '0;
    id_base   = (hc_r == 3'd0) ? 16'd0 : id_r;
    len_base  = (hc_r == 3'd0) ? 16'd0 : len_r;
    hc_inc    = hc_r + 3'd1;
    if (accept) begin
      case (phase_r)
        PH_HEADER, PH_BODY: begin
          if (link_error) begin
            // Close the session on a link error
            phase_nxt           = PH_CLOSED;
            push                = 1'b1;
            push_data.msg_id    = 16'd0;
            push_data.body_byte = 8'd0;
            push_data.last      = 1'b1;
            push_data.status    = ST_LINK;
          end else if (phase_r == PH_HEADER) begin
            // Shift the byte into the id or the length
            if (hc_r < ID_BYTES) begin
              id_nxt  = {id_base[7:0], rx_byte};
              len_nxt = len_base;
            end else begin
              id_nxt  = id_base;
              len_nxt = {len_base[7:0], rx_byte};
            end
            if (hc_inc == HDR_TOTAL) begin
              hc_nxt = 3'd0;
              if (len_nxt > max_body_len) begin
                phase_nxt           = PH_CLOSED;
                push                = 1'b1;
                push_data.msg_id    = id_nxt;
                push_data.body_byte = 8'd0;
                push_data.last      = 1'b1;
                push_data.status    = ST_TOO_LONG;
              end else if (len_nxt == 16'd0) begin
                push                = 1'b1;
                push_data.msg_id    = id_nxt;
                push_data.body_byte = 8'd0;
                push_data.last      = 1'b1;
                push_data.status    = ST_EMPTY;
              end else begin
                rem_nxt   = len_nxt;
                phase_nxt = PH_BODY;
              end
            end else begin
              hc_nxt = hc_inc;
            end
          end else begin
            // Body byte: emit it and count down
            rem_nxt             = rem_r - 16'd1;
            push                = 1'b1;
            push_data.msg_id    = id_r;
            push_data.body_byte = rx_byte;
            push_data.last      = (rem_r == 16'd1);
            push_data.status    = ST_BODY;
            if (rem_r == 16'd1) begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        default: begin
          // Closed session: drop everything
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Hold the parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hc_r    <= 3'd0;
      id_r    <= 16'd0;
      len_r   <= 16'd0;
      rem_r   <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/tlvd_queue.sv =====
// tlvd_queue: short result queue between the parser and the output stage.
// Depends on tlvd_pkg for the result type and depth.
`default_nettype none
module tlvd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tlvd_pkg::res_t push_data,
  input  wire logic           pop,
  output tlvd_pkg::res_t      head,
  output logic                not_empty,
  output logic                full
);
  import tlvd_pkg::*;

  res_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // Store pushed results
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tlvd_back.sv =====
// tlvd_back: output register stage of the TLV deframer.
// Depends on tlvd_pkg; pops the result queue and drives the master-side stream.
`default_nettype none
module tlvd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlvd_pkg::res_t head,
  input  wire logic           q_not_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tlvd_pkg::res_t      out_data
);
  import tlvd_pkg::*;

  logic valid_r;
  res_t data_r;

  // Load a new result when the register is empty or being drained
  assign pop       = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

endmodule
`default_nettype wire

// ===== design/tlv_stream_deframer.sv =====
// tlv_stream_deframer: splits a byte stream into id/length-prefixed messages.
// Path: an accepted byte's result is written into the result queue, then into the output register that drives out_.
// Throughput: one byte per cycle; the input stalls only when the four-entry result
// queue fills while the output side is stalled.
// Reset: synchronous active-low rst_n clears parser, queue and output valid, and sets
// max_body_len to 1024; a closed session stays closed until reset.
`default_nettype none
module tlv_stream_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] link_error
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] msg_id, [23:16] body_byte
  output logic             out_tlast,
  output logic [1:0]       out_tuser,  // [1:0] status
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import tlvd_pkg::*;

  logic [15:0] max_len_r;
  logic        in_accept;
  logic        push;
  res_t        push_data;
  logic        pop;
  res_t        head;
  logic        q_not_empty;
  logic        q_full;
  res_t        out_data;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {16'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == 1'b0)) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  // Take a byte whenever the queue has room
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  tlvd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .rx_byte      (in_tdata),
    .link_error   (in_tuser[0]),
    .max_body_len (max_len_r),
    .push_data    (push_data),
    .push         (push)
  );

  tlvd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tlvd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_data)
  );

  // Pack the result onto the stream
  assign out_tdata = {out_data.body_byte, out_data.msg_id};
  assign out_tlast = out_data.last;
  assign out_tuser = out_data.status;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for tlv_stream_deframer, the byte stream to id/length message splitter.
// Drives random byte streams with random idling on both sides and checks each result against
// a local model of the parser. Depends on tlvd_pkg and the deframer RTL only.
`timescale 1ns / 1ps
module tb;
  import tlvd_pkg::*;

  localparam logic [2:0] REG_MAX_BODY_LEN = 3'd0;
  localparam logic [2:0] REG_UNMAPPED     = 3'd4;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_BYTES   = 300;

  typedef enum logic [1:0] {PS_HEADER, PS_BODY, PS_CLOSED} parse_phase_t;

  // One stimulus transaction; want is used only where typed is set
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_err;
    logic       typed;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_RES = '0;

  // Directed opening: empty messages, extreme ids and bytes, a short body
  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{16'h0000, 8'h00, 1'b1, ST_EMPTY}},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, '{16'hFFFF, 8'hFF, 1'b1, ST_BODY}},
    '{8'h12, 1'b0, 1'b0, NO_RES},
    '{8'h34, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b0, NO_RES},
    '{8'hA5, 1'b0, 1'b0, NO_RES},
    '{8'h5A, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{16'hA55A, 8'h00, 1'b1, ST_EMPTY}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] rx_byte
  logic [0:0]  in_tuser = '0;    // [0] link_error
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [15:0] msg_id, [23:16] body_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;        // [1:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tlv_stream_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state and configuration
  parse_phase_t prs_phase = PS_HEADER;
  logic [2:0]   hdr_count = '0;
  logic [15:0]  id_acc = '0;
  logic [15:0]  len_acc = '0;
  logic [15:0]  body_left = '0;
  logic [15:0]  max_len = MAX_LEN_RESET;

  res_t pending_results [$];
  int   fail_count = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   hold_req = 0;
  bit   in_burst = 1'b0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;

  // Advance the parser model by one byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] rx, input logic err, output res_t r);
    r = '0;
    if (prs_phase != PS_HEADER && prs_phase != PS_BODY) return 1'b0;
    if (err) begin
      prs_phase = PS_CLOSED;
      r.last = 1'b1;
      r.status = ST_LINK;
      return 1'b1;
    end
    if (prs_phase == PS_HEADER) begin
      if (hdr_count == 3'd0) begin
        id_acc = '0;
        len_acc = '0;
      end
      if (hdr_count < ID_BYTES) id_acc = {id_acc[7:0], rx};
      else len_acc = {len_acc[7:0], rx};
      hdr_count = hdr_count + 3'd1;
      if (hdr_count < HDR_TOTAL) return 1'b0;
      hdr_count = '0;
      r.msg_id = id_acc;
      r.last = 1'b1;
      if (len_acc > max_len) begin
        prs_phase = PS_CLOSED;
        r.status = ST_TOO_LONG;
        return 1'b1;
      end
      if (len_acc == 16'd0) begin
        r.status = ST_EMPTY;
        return 1'b1;
      end
      body_left = len_acc;
      prs_phase = PS_BODY;
      return 1'b0;
    end
    body_left = body_left - 16'd1;
    r.msg_id = id_acc;
    r.body_byte = rx;
    r.status = ST_BODY;
    r.last = (body_left == 16'd0);
    if (body_left == 16'd0) prs_phase = PS_HEADER;
    return 1'b1;
  endfunction

  function automatic int draw_in_gap();
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    return (in_burst || in_calm) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic int draw_out_gap();
    if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    return out_calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Offer one byte, wait for the handshake, then record what it should produce
  task automatic send_row(input stim_row_t row);
    int   gap;
    res_t r;
    bit   has_res;
    gap = draw_in_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= row.rx_byte;
    in_tuser <= row.link_err;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    has_res = deframe_byte(row.rx_byte, row.link_err, r);
    if (row.typed) pending_results.push_back(row.want);
    else if (has_res) pending_results.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_row('{rx, 1'b0, 1'b0, NO_RES});
  endtask

  // Header then len random body bytes
  task automatic send_msg(input logic [15:0] id, input logic [15:0] len);
    send_byte(id[15:8]);
    send_byte(id[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    repeat (len) send_byte(8'($urandom));
  endtask

  // Stop offering and wait until every expected result is in, plus settling time
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == REG_MAX_BODY_LEN) max_len = data[15:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read back the length limit and compare with the model copy
  task automatic check_max_len();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= REG_MAX_BODY_LEN;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {16'h0000, max_len}) begin
      $display("%0t: max_body_len readback expected %h got %h", $time,
               {16'h0000, max_len}, cfg_prdata);
      fail_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a body length that never exceeds the current limit; mostly short bodies
  function automatic logic [15:0] draw_len();
    int sel;
    int lim_short;
    int lim_mid;
    sel = $urandom_range(0, 99);
    lim_short = (max_len < 12) ? max_len : 12;
    lim_mid = (max_len < 80) ? max_len : 80;
    if (max_len == 16'd0 || sel < 10) return 16'd0;
    if (sel < 14) return (max_len <= 16'd300) ? max_len : 16'(lim_mid);
    if (sel < 80) return 16'($urandom_range(1, lim_short));
    return 16'($urandom_range(1, lim_mid));
  endfunction

  // Result side: random stalls, plus a long hold when asked for
  initial begin : result_sink
    int wait_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        wait_cycles = hold_req;
        hold_req = 0;
      end else begin
        wait_cycles = draw_out_gap();
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time,
                 {out_tdata, out_tlast, out_tuser});
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("msg_id", want.msg_id, out_tdata[15:0]);
        check_field("body_byte", want.body_byte, out_tdata[23:16]);
        check_field("last", want.last, out_tlast);
        check_field("status", want.status, out_tuser);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] limits [6];
    logic [15:0] tail_len;
    int          phase_start;
    int          cut;
    bit          pressure_done;
    pressure_done = 1'b0;
    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd1;
    limits[3] = 16'($urandom_range(2, 40));
    limits[4] = 16'd300;
    limits[5] = 16'($urandom_range(301, 65534));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening runs with the reset limit
    foreach (DIRECTED_ROWS[i]) send_row(DIRECTED_ROWS[i]);
    drain_results();
    check_max_len();

    // A write outside the register map must leave the limit alone
    apb_write(REG_UNMAPPED, $urandom);
    check_max_len();

    // Random messages under a series of length limits
    foreach (limits[p]) begin
      apb_write(REG_MAX_BODY_LEN, {16'($urandom_range(0, 65535)), limits[p]});
      check_max_len();
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_BYTES) begin
        // Stall the result side while bytes keep being offered with no gaps
        if (!pressure_done && max_len == 16'hFFFF && items_sent - phase_start > 120) begin
          drain_results();
          hold_req = 150;
          in_burst = 1'b1;
          send_msg(16'($urandom), 16'd60);
          in_burst = 1'b0;
          drain_results();
          pressure_done = 1'b1;
        end
        send_msg(16'($urandom), draw_len());
        if ($urandom_range(0, 39) == 0) drain_results();
      end
      drain_results();
    end

    // Close the session: either a link error or an oversize header
    if ($urandom_range(0, 1) == 0) begin
      tail_len = 16'($urandom_range(2, 10));
      cut = $urandom_range(0, 3 + tail_len);
      for (int i = 0; i < cut; i++) begin
        case (i)
          0: send_byte(8'($urandom));
          1: send_byte(8'($urandom));
          2: send_byte(tail_len[15:8]);
          3: send_byte(tail_len[7:0]);
          default: send_byte(8'($urandom));
        endcase
      end
      send_row('{8'($urandom), 1'b1, 1'b1, '{16'h0000, 8'h00, 1'b1, ST_LINK}});
    end else begin
      tail_len = max_len + 16'd1;
      send_byte(8'hBE);
      send_byte(8'hEF);
      send_byte(tail_len[15:8]);
      send_row('{tail_len[7:0], 1'b0, 1'b1, '{16'hBEEF, 8'h00, 1'b1, ST_TOO_LONG}});
    end

    // A closed session ignores everything, link errors included
    for (int i = 0; i < 8; i++)
      send_row('{8'($urandom), (i == 2) ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, NO_RES});
    drain_results();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
